[rtl/core/per_cpu_page_free_list_allocator_assert.svh]
// Assertion macros for the per-CPU page allocator.
// Each check is compiled only in simulation; synthesis sees empty bodies.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PCPFL_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pcpfl assertion failed");

// Next-cycle implication.
`define PCPFL_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pcpfl assertion failed");

`else

`define PCPFL_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PCPFL_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

[rtl/core/pcpfl_pkg.sv]
package pcpfl_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 56;
  localparam int CPU_ID_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int CPU_COUNT_DEF  = 8;
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_STOP  = 1'b1;

  // Operation codes
  localparam logic FUNC_FREE  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef struct packed {
    logic                func;
    logic [CPU_ID_W-1:0] cpu_id;
    logic [ADDR_W-1:0]   page_addr;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_addr;
    logic              granted;
    logic              bad_free;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

endpackage

[rtl/core/pcpfl_link_ram.sv]
// Link table: one write port, one registered read port.
module pcpfl_link_ram #(
  parameter int DEPTH  = pcpfl_pkg::MAX_PAGES_DEF,
  parameter int IDX_W  = 15,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/per_cpu_page_free_list_allocator.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  pcpfl_pkg::req_item_t (func, cpu_id, page_addr)
// rsp      out        rsp_valid/rsp_stall  pcpfl_pkg::rsp_item_t (granted_addr, granted, bad_free)
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data (region_start, region_stop)
//
// A free is checked and written back in the EXEC cycle, once rsp can take the result.
// An alloc reads the link RAM in EXEC; POP uses the registered read data and finishes once rsp can take it.
// rst (synchronous) empties all lists and clears the region registers; links are not cleared.
// The next item is accepted in the cycle an item finishes, so no bubble between items.
// rsp holds one finished item; a stalled rsp holds the next item in its last state.
`include "per_cpu_page_free_list_allocator_assert.svh"

module per_cpu_page_free_list_allocator #(
  parameter int CPU_COUNT  = pcpfl_pkg::CPU_COUNT_DEF,
  parameter int MAX_PAGES  = pcpfl_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpfl_pkg::PAGE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pcpfl_pkg::req_item_t                req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output pcpfl_pkg::rsp_item_t                rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcpfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcpfl_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int AW  = pcpfl_pkg::ADDR_W;
  localparam int IW  = pcpfl_pkg::CPU_ID_W;
  localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;  // slot
  localparam int HW  = $clog2(MAX_PAGES + 1);                     // slot+1, 0 = empty
  localparam int PBL = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] PB_MASK = AW'(PAGE_BYTES - 1);

  // ---------------------------------------------------------------
  // Configuration. base is region_start rounded up to a page, kept
  // alongside so the datapath never redoes the rounding.
  // ---------------------------------------------------------------
  logic [AW-1:0] region_start;
  logic [AW-1:0] region_stop;
  logic [AW-1:0] base;
  logic [AW-1:0] start_up;

  assign cfg_ready = 1'b1;
  assign start_up  = cfg_data + PB_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_stop  <= '0;
      base         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcpfl_pkg::REG_REGION_START: begin
          region_start <= cfg_data;
          base         <= start_up & ~PB_MASK;
        end
        pcpfl_pkg::REG_REGION_STOP: begin
          region_stop <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  pcpfl_pkg::state_t    state;
  pcpfl_pkg::state_t    state_next;
  pcpfl_pkg::req_item_t it;          // item in work
  logic                 req_acc;
  logic                 rsp_free;    // output register can take an item
  logic                 finish;
  logic                 wr_en;
  logic                 rd_en;
  logic                 is_alloc;

  // Heads in flops: small, reset to empty, nonempty flags feed the steal search.
  logic [HW-1:0]        heads [CPU_COUNT];
  logic [HW-1:0]        head_sel;
  logic [HW-1:0]        rd_data;

  logic [CW-1:0]        cpu;
  logic [CW-1:0]        srch_tgt;
  logic                 srch_found;
  logic [CW-1:0]        sel_cpu;

  logic                 bad;
  logic [AW-1:0]        diff;
  logic [SW-1:0]        free_slot;

  logic                 pop_found;
  logic [CW-1:0]        pop_tgt;
  logic [SW-1:0]        pop_slot;

  pcpfl_pkg::rsp_item_t rsp_next;

  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_acc  = req_valid && !req_stall;
  assign is_alloc = (it.func == pcpfl_pkg::FUNC_ALLOC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcpfl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      it <= req;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pcpfl_pkg::ST_IDLE: begin
        if (req_acc) state_next = pcpfl_pkg::ST_EXEC;
      end
      pcpfl_pkg::ST_EXEC: begin
        if (is_alloc) begin
          state_next = pcpfl_pkg::ST_POP;
        end else if (rsp_free) begin
          state_next = req_acc ? pcpfl_pkg::ST_EXEC : pcpfl_pkg::ST_IDLE;
        end
      end
      pcpfl_pkg::ST_POP: begin
        if (rsp_free) begin
          state_next = req_acc ? pcpfl_pkg::ST_EXEC : pcpfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcpfl_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    finish    = ((state == pcpfl_pkg::ST_EXEC) && !is_alloc && rsp_free) ||
                ((state == pcpfl_pkg::ST_POP) && rsp_free);
    req_stall = !((state == pcpfl_pkg::ST_IDLE) || finish);
    // a good free writes back only once, in the cycle it finishes; a bad free does not write
    wr_en     = (state == pcpfl_pkg::ST_EXEC) && !is_alloc && rsp_free && !bad;
    rd_en     = (state == pcpfl_pkg::ST_EXEC) && is_alloc;
  end

  // ---------------------------------------------------------------
  // EXEC: cpu_id modulo CPU_COUNT by repeated subtract (narrow)
  // ---------------------------------------------------------------
  always_comb begin
    logic [IW-1:0] acc;
    acc = it.cpu_id;
    for (int k = 0; k < (2 ** IW) - 1; k++) begin
      if (acc >= CPU_COUNT) acc = acc - IW'(CPU_COUNT);
    end
    cpu = CW'(acc);
  end

  // steal search: first nonempty list from cpu upward, wrapping
  always_comb begin
    logic [CW:0] idx;
    srch_found = 1'b0;
    srch_tgt   = cpu;
    idx        = '0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      idx = (CW + 1)'(cpu) + (CW + 1)'(i);
      if (idx >= CPU_COUNT) idx = idx - (CW + 1)'(CPU_COUNT);
      if (heads[idx[CW-1:0]] != '0) begin
        srch_found = 1'b1;
        srch_tgt   = idx[CW-1:0];
      end
    end
  end

  assign sel_cpu  = is_alloc ? srch_tgt : cpu;
  assign head_sel = heads[sel_cpu];

  // free checks; aligned and >= region_start implies >= base
  always_comb begin
    logic misalign;
    logic below;
    logic above;
    logic over;
    misalign  = |it.page_addr[PBL-1:0];
    below     = it.page_addr < region_start;
    above     = it.page_addr >= region_stop;
    diff      = it.page_addr - base;
    over      = diff[AW-1:PBL] >= MAX_PAGES;
    bad       = misalign || below || above || over;
    free_slot = diff[PBL +: SW];
  end

  pcpfl_link_ram #(
    .DEPTH  (MAX_PAGES),
    .IDX_W  (SW),
    .DATA_W (HW)
  ) u_links (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_slot),
    .wr_data (head_sel),
    .rd_en   (rd_en),
    .rd_addr (SW'(head_sel - HW'(1))),
    .rd_data (rd_data)
  );

  // alloc context carried into POP
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pop_found <= srch_found;
      pop_tgt   <= srch_tgt;
      pop_slot  <= SW'(head_sel - HW'(1));
    end
  end

  // heads: push on free, pop with the link read data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CPU_COUNT; c++) begin
        heads[c] <= '0;
      end
    end else if (wr_en) begin
      heads[cpu] <= HW'(free_slot) + HW'(1);
    end else if ((state == pcpfl_pkg::ST_POP) && rsp_free && pop_found) begin
      heads[pop_tgt] <= rd_data;
    end
  end

  // ---------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------
  always_comb begin
    rsp_next.granted_addr = '0;
    rsp_next.granted      = 1'b0;
    rsp_next.bad_free     = 1'b0;
    if (state == pcpfl_pkg::ST_POP) begin
      if (pop_found) begin
        rsp_next.granted_addr = base + (AW'(pop_slot) << PBL);
        rsp_next.granted      = 1'b1;
      end
    end else begin
      rsp_next.bad_free = bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= rsp_next;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `PCPFL_ASSERT_IMP(a_alloc_interlock, clk, rst, (state == pcpfl_pkg::ST_EXEC) && is_alloc, req_stall)
  `PCPFL_ASSERT_NXT(a_pop_head, clk, rst, (state == pcpfl_pkg::ST_POP) && rsp_free && pop_found, heads[$past(pop_tgt)] == $past(rd_data))
  `PCPFL_ASSERT_IMP(a_pop_entry, clk, rst, state == pcpfl_pkg::ST_POP, ($past(state) == pcpfl_pkg::ST_EXEC) || ($past(state) == pcpfl_pkg::ST_POP))
  `PCPFL_ASSERT_IMP(a_bad_no_grant, clk, rst, rsp_valid && rsp.bad_free, !rsp.granted && (rsp.granted_addr == '0))

endmodule
